[sv/stq_pkg.sv]
`timescale 1ns / 1ps

package stq_pkg;

    localparam int FUNC_W  = 2;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 5;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] time_value;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  head_time;
        logic [TIME_W-1:0]  tail_time;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic               rejected;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic ins;
        logic rem;
        logic load;
        logic rej;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
    } status_t;

endpackage

[sv/stq_ctrl.sv]
`timescale 1ns / 1ps

module stq_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [stq_pkg::FUNC_W-1:0] func,
    output logic                      m_valid,
    input  logic                      m_ready,
    input  stq_pkg::status_t          status,
    output stq_pkg::cmd_t             cmd
);

    localparam logic ST_IDLE = 1'b0;  // no result pending
    localparam logic ST_HOLD = 1'b1;  // result waits in output register

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_ready = (state_reg == ST_IDLE) || m_ready;
    assign m_valid = (state_reg == ST_HOLD);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd.load = accept;
        cmd.ins  = 1'b0;
        cmd.rem  = 1'b0;
        cmd.rej  = 1'b0;
        if (accept) begin
            case (func)
                stq_pkg::FN_INSERT: begin
                    cmd.ins = !status.full;
                    cmd.rej = status.full;
                end
                stq_pkg::FN_REMOVE: begin
                    cmd.rem = !status.empty;
                    cmd.rej = status.empty;
                end
                default: begin
                    // query, unused code acts as query
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_ready && !accept) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/stq_datapath.sv]
`timescale 1ns / 1ps

module stq_datapath #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  stq_pkg::cmd_t              cmd,
    input  logic [stq_pkg::TIME_W-1:0] time_in,
    output stq_pkg::status_t           status,
    output stq_pkg::out_item_t         result
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int OTW = stq_pkg::TIME_W;
    localparam int OCW = stq_pkg::COUNT_W;

    logic [TIME_BITS-1:0] cell_reg  [DEPTH];
    logic [TIME_BITS-1:0] cell_next [DEPTH];
    logic [DEPTH-1:0]     occ_reg;     // thermometer: bit i set when cell i holds an entry
    logic [DEPTH-1:0]     occ_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [TIME_BITS-1:0] tail_reg;
    logic [TIME_BITS-1:0] tail_next;
    stq_pkg::out_item_t   res_reg;
    stq_pkg::out_item_t   res_next;

    logic [TIME_BITS-1:0] t;
    logic [DEPTH-1:0]     gt;
    logic [DEPTH-1:0]     shift;
    logic [DEPTH-1:0]     place;

    assign t = TIME_BITS'(time_in);

    assign status.full  = occ_reg[DEPTH-1];
    assign status.empty = !occ_reg[0];
    assign result       = res_reg;

    // each cell compares against the new time; entries above it move up one
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = occ_reg[i] && (cell_reg[i] > t);
        end
        shift[0] = 1'b0;
        place[0] = gt[0] || !occ_reg[0];
        for (int i = 1; i < DEPTH; i++) begin
            shift[i] = gt[i-1];
            place[i] = !gt[i-1] && (gt[i] || (!occ_reg[i] && occ_reg[i-1]));
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_next[i] = cell_reg[i];
            if (cmd.ins) begin
                if (shift[i])      cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
                else if (place[i]) cell_next[i] = t;
            end else if (cmd.rem && (i < DEPTH - 1)) begin
                cell_next[i] = cell_reg[(i == DEPTH - 1) ? i : i + 1];
            end
        end
    end

    always_comb begin
        occ_next   = occ_reg;
        count_next = count_reg;
        tail_next  = tail_reg;
        if (cmd.ins) begin
            occ_next   = {occ_reg[DEPTH-2:0], 1'b1};
            count_next = count_reg + CW'(1);
            if (!occ_reg[0] || (t >= tail_reg)) tail_next = t;
        end else if (cmd.rem) begin
            occ_next   = {1'b0, occ_reg[DEPTH-1:1]};
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        res_next.head_time   = occ_next[0] ? OTW'(cell_next[0]) : '0;
        res_next.tail_time   = occ_next[0] ? OTW'(tail_next) : '0;
        res_next.entry_count = OCW'(count_next);
        res_next.is_empty    = !occ_next[0];
        res_next.rejected    = cmd.rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= '0;
            count_reg <= '0;
        end else begin
            occ_reg   <= occ_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_reg[i] <= cell_next[i];
        end
        tail_reg <= tail_next;
        if (cmd.load) res_reg <= res_next;
    end

endmodule

[sv/sorted_time_queue.sv]
`timescale 1ns / 1ps
// Channel   Ports                       Direction  Payload
// input     s_valid s_ready s_data      in         func, time_value
// result    m_valid m_ready m_data      out        head_time, tail_time, entry_count,
//                                                  is_empty, rejected
//
// One transaction per cycle: every cell compares and shifts in parallel in the
// cycle the input is accepted, and the result is loaded into the output register.
// The next input is taken while a result waits, as long as that result leaves
// in the same cycle. Synchronous active-low reset empties the queue; no clearing
// pass. A stalled result register stalls the input side.

module sorted_time_queue #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output stq_pkg::out_item_t m_data
);

    stq_pkg::cmd_t    cmd;
    stq_pkg::status_t status;

    stq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .func    (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stq_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .time_in (s_data.time_value),
        .status  (status),
        .result  (m_data)
    );

endmodule

[tb/sv/tb_sorted_time_queue.sv]
`timescale 1ns / 1ps

module tb_sorted_time_queue;
    import stq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int MAX_PRINTS  = 50;

    // the spare func code, handled as a query
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } op_mix_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    always #5 aclk = ~aclk;

    sorted_time_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Sorted-queue predictor plus the FIFO of queue snapshots still owed by the block.
    class time_queue_sb;
        logic [TIME_W-1:0] cells [QDEPTH];
        int                stored;
        out_item_t         owed_q [$];
        int                errors;

        function new();
            stored = 0;
            errors = 0;
        endfunction

        function void note_input(in_item_t it);
            out_item_t snap;
            int        pos;
            logic      rej;
            rej = 1'b0;
            case (it.func)
                FN_INSERT: begin
                    if (stored >= QDEPTH) begin
                        rej = 1'b1;
                    end else begin
                        // new time goes after all equal entries
                        pos = 0;
                        while (pos < stored && cells[pos] <= it.time_value)
                            pos++;
                        for (int i = stored; i > pos; i--)
                            cells[i] = cells[i-1];
                        cells[pos] = it.time_value;
                        stored++;
                    end
                end
                FN_REMOVE: begin
                    if (stored == 0) begin
                        rej = 1'b1;
                    end else begin
                        for (int i = 1; i < stored; i++)
                            cells[i-1] = cells[i];
                        stored--;
                    end
                end
                default: ;
            endcase
            snap.head_time   = (stored > 0) ? cells[0] : '0;
            snap.tail_time   = (stored > 0) ? cells[stored-1] : '0;
            snap.entry_count = stored[COUNT_W-1:0];
            snap.is_empty    = (stored == 0);
            snap.rejected    = rej;
            owed_q.push_back(snap);
        endfunction

        task report(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (owed_q.size() == 0) begin
                report("result with nothing pending", got.head_time, '0);
                return;
            end
            want = owed_q.pop_front();
            if (got.head_time !== want.head_time)
                report("head_time", got.head_time, want.head_time);
            if (got.tail_time !== want.tail_time)
                report("tail_time", got.tail_time, want.tail_time);
            if (got.entry_count !== want.entry_count)
                report("entry_count", got.entry_count, want.entry_count);
            if (got.is_empty !== want.is_empty)
                report("is_empty", got.is_empty, want.is_empty);
            if (got.rejected !== want.rejected)
                report("rejected", got.rejected, want.rejected);
        endtask
    endclass

    time_queue_sb sb;

    // monitor: sample pre-edge values of both handshakes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // receiver stall pattern: rotating mask, reloaded with a new character now and then
    logic [15:0] ready_pat   = 16'hFFFF;
    int          stall_timer = 0;

    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_timer <= $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0:       ready_pat <= '1;
                1:       ready_pat <= 16'($urandom) | 16'h0001;
                2:       ready_pat <= 16'($urandom & $urandom & $urandom) | 16'h0001;
                default: ready_pat <= 16'h00FF;
            endcase
        end else begin
            stall_timer <= stall_timer - 1;
            ready_pat   <= {ready_pat[0], ready_pat[15:1]};
        end
        m_ready <= ready_pat[0];
    end

    int burst_left = 0;

    task automatic send(input logic [FUNC_W-1:0] fn, input logic [TIME_W-1:0] tv);
        in_item_t it;
        it.func       = fn;
        it.time_value = tv;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // duplicates from a tiny pool, extremes, the top of the range, or anything
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 7);
            3: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            4, 5:    return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(op_mix_t mix);
        int r;
        int ins_pct;
        int rem_pct;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin ins_pct = 70; rem_pct = 15; end
            MIX_DRAIN: begin ins_pct = 15; rem_pct = 70; end
            default:   begin ins_pct = 40; rem_pct = 40; end
        endcase
        if (r < ins_pct)
            return FN_INSERT;
        else if (r < ins_pct + rem_pct)
            return FN_REMOVE;
        else if (r < 95)
            return FN_QUERY;
        else
            return FN_SPARE;
    endfunction

    initial begin
        op_mix_t mix;
        int      mix_left;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, ordering corners, full queue
        send(FN_QUERY, 32'h0);
        send(FN_REMOVE, 32'h0000_1234);
        send(FN_INSERT, 32'd100);
        send(FN_INSERT, 32'd40);           // below head, against a single entry
        send(FN_INSERT, 32'd100);          // equal to an entry
        send(FN_INSERT, 32'h0);
        send(FN_INSERT, 32'hFFFF_FFFF);
        send(FN_SPARE, 32'hFFFF_FFFF);
        repeat (QDEPTH - 5) send(FN_INSERT, $urandom);
        send(FN_INSERT, 32'd5);            // full: dropped
        send(FN_QUERY, 32'hA5A5_A5A5);
        send(FN_REMOVE, 32'h0);

        mix      = MIX_DRAIN;
        mix_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mix_left == 0) begin
                mix      = op_mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 40);
            end
            mix_left--;
            send(pick_func(mix), pick_time());
        end
        s_valid <= 1'b0;

        // let the monitor note the last accepted transaction before draining
        @(posedge aclk);
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (sb.errors == 0)
            $display("sorted_time_queue regression: pass");
        else
            $display("sorted_time_queue regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("sorted_time_queue regression: fail");
        $finish;
    end

endmodule
